// ===== sv/ffca_pkg.sv =====
`timescale 1ns / 1ps
// ffca_pkg: shared types and codes for the first-fit cell allocator.
// No dependencies; imported by ffca_front, ffca_back, the top level and the bench.
package ffca_pkg;

	localparam int OWNER_W = 5;
	localparam int SIZE_W  = 12;

	// request op field
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// result status field
	localparam logic [1:0] STATUS_ALLOC    = 2'd0;
	localparam logic [1:0] STATUS_NOFIT    = 2'd1;
	localparam logic [1:0] STATUS_RELEASED = 2'd2;

	// command kinds decided by the front end
	localparam logic [1:0] KIND_SCAN    = 2'd0;
	localparam logic [1:0] KIND_NOFIT   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// configuration register indexes
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]         kind;
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0]  size;
	} cmd_t;

endpackage

// ===== sv/ffca_ram.sv =====
`timescale 1ns / 1ps
// ffca_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/ffca_front.sv =====
`timescale 1ns / 1ps
// ffca_front: accepts request items, classifies them and queues commands.
// Depends on ffca_pkg.
module ffca_front import ffca_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hold,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [OWNER_W-1:0] owner_id,
	input  logic [SIZE_W-1:0]  request_size,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);

	cmd_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	cmd_t       new_cmd;
	logic       push;
	logic       pop;

	always_comb begin
		new_cmd.owner = owner_id;
		new_cmd.size  = request_size;
		if (op == OP_RELEASE) begin
			new_cmd.kind = KIND_RELEASE;
		end else if (owner_id == '0 || request_size == '0) begin
			new_cmd.kind = KIND_NOFIT;
		end else begin
			new_cmd.kind = KIND_SCAN;
		end
	end

	assign in_ready  = !hold && (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= new_cmd;
		end
	end

endmodule

// ===== sv/ffca_back.sv =====
`timescale 1ns / 1ps
// ffca_back: executes commands against the cell map (clear, scan, fill, release).
// Depends on ffca_pkg and ffca_ram.
module ffca_back import ffca_pkg::*; #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 64,
	parameter int ROW_W    = 6,
	parameter int COL_W    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] rows,
	input  logic [COL_W-1:0] cols,
	output logic             clear_busy,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [4:0]       start_row,
	output logic [5:0]       start_col
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_REL   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  lin_q;
	logic               issue_q;
	logic [ROW_W-1:0]   r_q;
	logic [COL_W-1:0]   c_q;
	logic [ADDR_W-1:0]  base_q;
	logic               vld_s1;
	logic [ROW_W-1:0]   r_s1;
	logic [COL_W-1:0]   c_s1;
	logic [ADDR_W-1:0]  base_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [SIZE_W-1:0]  run_q;
	logic [SIZE_W-1:0]  fill_left_q;
	logic [ROW_W-1:0]   sr_q;
	logic [COL_W-1:0]   sc_q;
	logic [ADDR_W-1:0]  sbase_q;
	logic [OWNER_W-1:0] owner_q;
	logic [SIZE_W-1:0]  size_q;
	logic [1:0]         res_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [4:0]         start_row_q;
	logic [5:0]         start_col_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [OWNER_W-1:0] rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [OWNER_W-1:0] wr_data;
	logic [ADDR_W-1:0]  cell_addr;
	logic               col_last;
	logic               row_last;
	logic               lin_last;
	logic               cell_free;
	logic               hit;
	logic [ROW_W-1:0]   st_r;
	logic [COL_W-1:0]   st_c;
	logic [ADDR_W-1:0]  st_base;
	logic               out_free;

	assign cell_addr = base_q + ADDR_W'(c_q);
	assign col_last  = ((COL_W+1)'(c_q) + 1'b1) >= (COL_W+1)'(cols);
	assign row_last  = ((ROW_W+1)'(r_q) + 1'b1) >= (ROW_W+1)'(rows);
	assign lin_last  = (lin_q == ADDR_W'(DEPTH - 1));
	assign cell_free = (rd_data == '0);
	assign hit = (state_q == ST_SCAN) && vld_s1 && cell_free &&
		(((SIZE_W+1)'(run_q) + 1'b1) == (SIZE_W+1)'(size_q));
	// start of the current free run: this cell if the run is just opening
	assign st_r    = (run_q == '0) ? r_s1 : sr_q;
	assign st_c    = (run_q == '0) ? c_s1 : sc_q;
	assign st_base = (run_q == '0) ? base_s1 : sbase_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cell_addr;
		wr_en   = 1'b0;
		wr_addr = cell_addr;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = lin_q;
			end
			ST_SCAN: begin
				rd_en = issue_q;
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_data = owner_q;
			end
			ST_REL: begin
				rd_en   = issue_q;
				rd_addr = lin_q;
				wr_en   = vld_s1 && (rd_data == owner_q);
				wr_addr = addr_s1;
			end
			default: begin
			end
		endcase
	end

	ffca_ram #(
		.WIDTH(OWNER_W),
		.DEPTH(DEPTH),
		.AW   (ADDR_W)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign clear_busy = (state_q == ST_CLEAR);
	assign cmd_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			lin_q       <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					lin_q <= lin_q + 1'b1;
					if (lin_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						owner_q <= cmd.owner;
						size_q  <= cmd.size;
						r_q     <= '0;
						c_q     <= '0;
						base_q  <= '0;
						lin_q   <= '0;
						run_q   <= '0;
						vld_s1  <= 1'b0;
						issue_q <= 1'b1;
						unique case (cmd.kind)
							KIND_SCAN: begin
								if (rows == '0 || cols == '0) begin
									res_q   <= STATUS_NOFIT;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_RELEASE: begin
								state_q <= ST_REL;
							end
							default: begin
								res_q   <= STATUS_NOFIT;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// read stage walks the active cells row-major
					if (issue_q) begin
						if (col_last) begin
							c_q    <= '0;
							r_q    <= r_q + 1'b1;
							base_q <= base_q + ADDR_W'(MAX_COLS);
							if (row_last) begin
								issue_q <= 1'b0;
							end
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
					vld_s1  <= issue_q;
					r_s1    <= r_q;
					c_s1    <= c_q;
					base_s1 <= base_q;
					// data stage tracks the free run
					if (hit) begin
						sr_q        <= st_r;
						sc_q        <= st_c;
						r_q         <= st_r;
						c_q         <= st_c;
						base_q      <= st_base;
						fill_left_q <= size_q;
						issue_q     <= 1'b0;
						vld_s1      <= 1'b0;
						state_q     <= ST_FILL;
					end else if (vld_s1) begin
						if (cell_free) begin
							if (run_q == '0) begin
								sr_q    <= r_s1;
								sc_q    <= c_s1;
								sbase_q <= base_s1;
							end
							run_q <= run_q + 1'b1;
						end else begin
							run_q <= '0;
						end
					end else if (!issue_q) begin
						res_q   <= STATUS_NOFIT;
						state_q <= ST_DONE;
					end
				end
				ST_FILL: begin
					if (col_last) begin
						c_q    <= '0;
						r_q    <= r_q + 1'b1;
						base_q <= base_q + ADDR_W'(MAX_COLS);
					end else begin
						c_q <= c_q + 1'b1;
					end
					fill_left_q <= fill_left_q - 1'b1;
					if (fill_left_q == SIZE_W'(1)) begin
						res_q   <= STATUS_ALLOC;
						state_q <= ST_DONE;
					end
				end
				ST_REL: begin
					// sweeps the whole store, including cells outside the active map
					if (issue_q) begin
						lin_q <= lin_q + 1'b1;
						if (lin_last) begin
							issue_q <= 1'b0;
						end
					end
					vld_s1  <= issue_q;
					addr_s1 <= lin_q;
					if (!issue_q && !vld_s1) begin
						res_q   <= STATUS_RELEASED;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_q;
						if (res_q == STATUS_ALLOC) begin
							start_row_q <= 5'(sr_q);
							start_col_q <= 6'(sc_q);
						end else begin
							start_row_q <= '0;
							start_col_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign start_row = start_row_q;
	assign start_col = start_col_q;

`ifndef SYNTH
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLEAR || state_q == ST_FILL || state_q == ST_REL))
		else $error("map written outside clear, fill or release");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (run_q < size_q))
		else $error("free run reached request size without a fit");

	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && $past(state_q) == ST_SCAN) |-> (fill_left_q == size_q))
		else $error("fill started with wrong length");

	a_alloc_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_q == STATUS_ALLOC) |->
		((ROW_W+1)'(sr_q) < (ROW_W+1)'(rows) && (COL_W+1)'(sc_q) < (COL_W+1)'(cols)))
		else $error("allocated run starts outside the active map");
`endif

endmodule

// ===== sv/first_fit_cell_allocator.sv =====
`timescale 1ns / 1ps
// first_fit_cell_allocator: top level, config registers, front end and back end.
// Depends on ffca_pkg, ffca_front, ffca_back (which uses ffca_ram).
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// request  | in_valid / in_ready  | op, owner_id, request_size
// result   | out_valid/out_ready  | status, start_row, start_col
// config   | cfg_we (no wait)     | cfg_addr, cfg_wdata
//
// Allocate scans one cell per cycle through the map RAM over the active
// rows*cols (counts after clamping), then fills request_size cells when a
// run fits; release sweeps every RAM entry, MAX_ROWS*MAX_COLS. Allocations
// with owner zero or size zero answer no-fit without a scan.
// Reset: a clearing pass writes every RAM entry (MAX_ROWS*MAX_COLS of them) and
// no item is accepted until it ends; config writes are taken at any time.
// Stalls: a two-entry queue lets requests be accepted while the back end works
// or a result waits in the output register.
module first_fit_cell_allocator import ffca_pkg::*; #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [6:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [OWNER_W-1:0] owner_id,
	input  logic [SIZE_W-1:0]  request_size,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [4:0]         start_row,
	output logic [5:0]         start_col
);

	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLS + 1);

	logic [5:0]       row_count_q;
	logic [6:0]       col_count_q;
	logic [ROW_W-1:0] rows;
	logic [COL_W-1:0] cols;
	logic             clear_busy;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;

	// register write port; values above the map size are clamped below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 6'd20;
			col_count_q <= 7'd50;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROW_COUNT: row_count_q <= cfg_wdata[5:0];
				REG_COL_COUNT: col_count_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign rows = (32'(row_count_q) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(row_count_q);
	assign cols = (32'(col_count_q) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(col_count_q);

	// front: accept and classify, queue commands
	ffca_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.hold        (clear_busy),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.owner_id    (owner_id),
		.request_size(request_size),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	// back: scan, fill and release over the map RAM, output register
	ffca_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.ROW_W   (ROW_W),
		.COL_W   (COL_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rows      (rows),
		.cols      (cols),
		.clear_busy(clear_busy),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.start_row (start_row),
		.start_col (start_col)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for first_fit_cell_allocator, with an own owner-map model.
// Depends on ffca_pkg and the allocator RTL; no files, no arguments.
module tb_top;
	import ffca_pkg::*;

	localparam int MAP_ROWS        = 32;
	localparam int MAP_COLS        = 64;
	localparam int MAP_CELLS       = MAP_ROWS * MAP_COLS;
	// The limit covers the worst item (full release sweep or full scan plus full fill)
	// for each of ~290 items, plus bursts, reset clearing and the hold-off, taken 3x
	localparam int LIMIT_CYCLES    = 4_000_000;
	localparam int HOLDOFF_CYCLES  = 6000;   // long receiver stall to back up the input
	localparam int TAIL_CYCLES     = 4500;   // beyond one full scan plus fill

	typedef struct packed {
		logic               op;
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0]  size;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] row;
		logic [5:0] col;
	} grant_t;

	// all block inputs start at known values
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic               cfg_addr     = 1'b0;
	logic [6:0]         cfg_wdata    = '0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               op           = 1'b0;
	logic [OWNER_W-1:0] owner_id     = '0;
	logic [SIZE_W-1:0]  request_size = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [1:0]         status;
	logic [4:0]         start_row;
	logic [5:0]         start_col;

	// bench state
	request_t           request_q [$];     // items waiting to be offered
	grant_t             grant_q [$];       // predicted results, oldest first
	int                 live_owners [$];   // owners the generator believes hold cells
	logic [OWNER_W-1:0] owner_map [MAP_CELLS];
	logic [5:0]         row_cfg = 6'd20;   // model copy of the registers
	logic [6:0]         col_cfg = 7'd50;
	request_t           offered;
	int                 send_idle = 0;
	int                 recv_idle = 0;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	logic               quiet = 1'b0;       // no idling on either side
	logic               pressure_go = 1'b0;
	logic               holding = 1'b0;

	first_fit_cell_allocator #(
		.MAX_ROWS(MAP_ROWS),
		.MAX_COLS(MAP_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.owner_id(owner_id),
		.request_size(request_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.start_row(start_row),
		.start_col(start_col)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// reset asserted from the start and released once
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("first_fit_cell_allocator: mismatch");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR @%0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Model of one request: first-fit scan over the active region in row-major
	// order, runs wrap from the last active column into column 0 of the next row.
	// Release clears the owner in the whole store, active region or not.
	function automatic grant_t place_request(input request_t rq);
		grant_t g;
		int rows;
		int cols;
		int r;
		int c;
		int n;
		int run;
		int sr;
		int sc;
		bit found;
		g.status = STATUS_NOFIT;
		g.row = '0;
		g.col = '0;
		rows = (row_cfg > MAP_ROWS) ? MAP_ROWS : row_cfg;
		cols = (col_cfg > MAP_COLS) ? MAP_COLS : col_cfg;
		if (rq.op == OP_RELEASE) begin
			// owner zero means free, so it clears nothing
			if (rq.owner != '0)
				for (n = 0; n < MAP_CELLS; n++)
					if (owner_map[n] == rq.owner)
						owner_map[n] = '0;
			g.status = STATUS_RELEASED;
			return g;
		end
		if (rq.owner == '0 || rq.size == '0)
			return g;
		run = 0;
		sr = 0;
		sc = 0;
		found = 1'b0;
		for (r = 0; r < rows && !found; r++) begin
			for (c = 0; c < cols && !found; c++) begin
				if (owner_map[r * MAP_COLS + c] == '0) begin
					if (run == 0) begin
						sr = r;
						sc = c;
					end
					run++;
					if (run == rq.size)
						found = 1'b1;
				end else begin
					run = 0;
				end
			end
		end
		if (!found)
			return g;
		r = sr;
		c = sc;
		for (n = 0; n < rq.size; n++) begin
			owner_map[r * MAP_COLS + c] = rq.owner;
			c++;
			if (c >= cols) begin
				c = 0;
				r++;
			end
		end
		g.status = STATUS_ALLOC;
		g.row = sr[4:0];
		g.col = sc[5:0];
		return g;
	endfunction

	// Driver: predicts on acceptance, then offers the next item or idles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				grant_q.push_back(place_request(offered));
			if (!in_valid || in_ready) begin
				if (send_idle > 0) begin
					send_idle--;
					in_valid <= 1'b0;
				end else if (request_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					// idle burst, this one included
					send_idle = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else begin
					offered = request_q.pop_front();
					op <= offered.op;
					owner_id <= offered.owner;
					request_size <= offered.size;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result status=%0d row=%0d col=%0d",
						status, start_row, start_col));
				end else begin
					want = grant_q.pop_front();
					if (status !== want.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							status, want.status));
					if (start_row !== want.row)
						flag_mismatch($sformatf("start_row got %0d want %0d",
							start_row, want.row));
					if (start_col !== want.col)
						flag_mismatch($sformatf("start_col got %0d want %0d",
							start_col, want.col));
				end
			end
			if (holding) begin
				out_ready <= 1'b0;
			end else if (recv_idle > 0) begin
				recv_idle--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_idle = $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off: results back up, the two-entry queue fills and
	// in_ready drops while the driver keeps offering.
	initial begin : receiver_holdoff
		wait (pressure_go);
		holding <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	task automatic queue_request(input logic rq_op, input int rq_owner, input int rq_size);
		request_t rq;
		rq.op = rq_op;
		rq.owner = rq_owner[OWNER_W-1:0];
		rq.size = rq_size[SIZE_W-1:0];
		request_q.push_back(rq);
	endtask

	// wait until every item is offered, accepted and answered
	task automatic wait_idle();
		do
			@(posedge clk);
		while (request_q.size() != 0 || in_valid || grant_q.size() != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		if (idx == REG_ROW_COUNT)
			row_cfg = val[5:0];
		else
			col_cfg = val;
	endtask

	// Mostly allocations of sizes that fit, with releases of owners that hold
	// cells, so the map fills, fragments and frees; the rest is odd sizes,
	// owner zero and stray releases.
	task automatic queue_random(input int count, input int cells);
		int k;
		int pick;
		int idx;
		int owner;
		int size;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 16 && live_owners.size() > 0) begin
				idx = $urandom_range(0, live_owners.size() - 1);
				owner = live_owners[idx];
				live_owners.delete(idx);
				queue_request(OP_RELEASE, owner, $urandom_range(0, 4095));
			end else if (pick < 20) begin
				queue_request(OP_RELEASE, $urandom_range(0, 31), $urandom_range(0, 4095));
			end else begin
				owner = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 31);
				case ($urandom_range(0, 19))
					0: size = 0;
					1: size = $urandom_range(2048, 4095);
					2: size = $urandom_range(cells, cells + 1);
					default: size = $urandom_range(1, (cells / 3 > 1) ? cells / 3 : 1);
				endcase
				if (owner != 0)
					live_owners.push_back(owner);
				queue_request(OP_ALLOC, owner, size);
			end
		end
	endtask

	task automatic run_phase(input int rows, input int cols, input int count, input bit press);
		int eff_rows;
		int eff_cols;
		wait_idle();
		write_reg(REG_ROW_COUNT, rows[6:0]);
		write_reg(REG_COL_COUNT, cols[6:0]);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (press)
			pressure_go <= 1'b1;
		eff_rows = (rows > MAP_ROWS) ? MAP_ROWS : rows;
		eff_cols = (cols > MAP_COLS) ? MAP_COLS : cols;
		queue_random(count, eff_rows * eff_cols);
	endtask

	initial begin : stimulus
		foreach (owner_map[i])
			owner_map[i] = '0;
		do
			@(posedge clk);
		while (!arst_n);

		// directed, reset geometry 20 x 50 (1000 cells)
		queue_request(OP_ALLOC, 1, 1);        // first cell
		queue_request(OP_ALLOC, 31, 50);      // run crosses the row end
		queue_request(OP_ALLOC, 2, 0);        // zero size
		queue_request(OP_ALLOC, 0, 5);        // owner zero on allocate
		queue_request(OP_ALLOC, 3, 4095);     // all size bits set
		queue_request(OP_ALLOC, 4, 2048);     // bigger than the map
		queue_request(OP_ALLOC, 5, 1001);     // one past the map
		queue_request(OP_RELEASE, 0, 0);      // owner zero on release
		queue_request(OP_RELEASE, 31, 0);
		queue_request(OP_ALLOC, 6, 10);       // refills the freed hole
		queue_request(OP_ALLOC, 7, 949);
		queue_request(OP_ALLOC, 8, 41);       // one more than what is left
		queue_request(OP_ALLOC, 9, 40);       // exactly what is left
		queue_request(OP_RELEASE, 7, 4095);   // size ignored on release
		queue_request(OP_ALLOC, 10, 949);
		queue_request(OP_RELEASE, 30, 0);     // owner with no cells
		queue_request(OP_RELEASE, 1, 0);
		queue_request(OP_RELEASE, 6, 0);
		queue_request(OP_RELEASE, 9, 0);
		queue_request(OP_RELEASE, 10, 0);
		queue_request(OP_ALLOC, 12, 1000);    // whole map
		queue_request(OP_ALLOC, 21, 3);       // map full

		// random phases; some owners survive the geometry changes
		run_phase(1, 1, 10, 1'b0);
		run_phase(0, 50, 5, 1'b0);          // no rows
		run_phase(20, 0, 5, 1'b0);          // no columns
		run_phase(4, 8, 50, 1'b1);          // receiver hold-off here
		run_phase(63, 127, 25, 1'b0);       // clamped to the full map
		run_phase(32, 64, 25, 1'b0);
		run_phase(3, 5, 40, 1'b0);          // shrunk, old owners outside
		run_phase(1, 64, 30, 1'b0);
		run_phase(32, 1, 30, 1'b0);
		wait_idle();
		quiet <= 1'b1;
		run_phase(7, 13, 50, 1'b0);
		wait_idle();

		// any late or extra result shows up in the monitor
		repeat (TAIL_CYCLES) @(posedge clk);
		if (grant_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", grant_q.size()));
		if (mismatch_count == 0)
			$display("first_fit_cell_allocator: match");
		else
			$display("first_fit_cell_allocator: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ffca_pkg.sv
sv/ffca_ram.sv
sv/ffca_front.sv
sv/ffca_back.sv
sv/first_fit_cell_allocator.sv
tb/sv/tb_top.sv
